// File: hdl/longest_decreasing_grid_path_defines.svh
// Assertion macros shared by the longest decreasing grid path block.
`ifndef LONGEST_DECREASING_GRID_PATH_DEFINES_SVH
`define LONGEST_DECREASING_GRID_PATH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LDGP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LDGP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ldgp_pkg.sv
// Shared types and constants for the longest decreasing grid path block.
`timescale 1ns / 1ps

package ldgp_pkg;

   localparam int MAX_ROWS_DEF   = 16;
   localparam int MAX_COLS_DEF   = 16;
   localparam int VALUE_BITS_DEF = 16;

   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_ROWS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_COLS = CSR_INDEX_W'(1);

   localparam logic [CSR_DATA_W-1:0] GRID_ROWS_RESET = CSR_DATA_W'(16);
   localparam logic [CSR_DATA_W-1:0] GRID_COLS_RESET = CSR_DATA_W'(16);

   localparam int DIR_W = 3;

   // Neighbor order: right, down, left, up; then the frame is finished.
   typedef enum logic [DIR_W-1:0] {
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT,
      DIR_UP,
      DIR_DONE
   } dir_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_ROOT,
      ST_ROOT_LD,
      ST_STEP,
      ST_CHECK,
      ST_POP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_cell;
      logic end_job;
      logic start;
      logic root_skip;
      logic root_read;
      logic root_push;
      logic dir_next;
      logic retire;
      logic root_close;
      logic check;
      logic parent_load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic short_grid;
      logic root_done;
      logic root_valid;
      logic dir_done;
      logic nb_ok;
      logic depth_gt1;
      logic rsp_busy;
   } status_type;

endpackage

// File: hdl/longest_decreasing_grid_path.sv
// Top level: longest strictly decreasing 4-neighbor path over a loaded grid.
`timescale 1ns / 1ps
`include "longest_decreasing_grid_path_defines.svh"

//  channel  direction  handshake                payload
//  req      in         req_valid / req_ready    req_cell_value, req_last_cell
//  rsp      out        rsp_valid / rsp_ready    rsp_path_length, rsp_size_error
//  csr      in         csr_valid / csr_ready    csr_index, csr_wdata
//
//  Cells load one item per cycle while req_ready is high, stored row-major
//  in the grid memory. After the last cell the search runs: a setup step,
//  then per grid cell a root scan or parent reload, four direction steps,
//  one check per in-grid neighbor and a retire, paced by the single read
//  port on the grid and memo memories; closing steps present the result.
//  An early last flag answers in the next cycle with an error result.
//  Memo-valid flags are flops, all cleared at the start of each search.
//  req_ready stays low during the search; a last item also waits for a free
//  result slot. The csr port always takes writes. Reset is synchronous.

module longest_decreasing_grid_path #(
   parameter int MAX_ROWS   = ldgp_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = ldgp_pkg::MAX_COLS_DEF,
   parameter int VALUE_BITS = ldgp_pkg::VALUE_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Grid cells in
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [VALUE_BITS-1:0]             req_cell_value,
   input  logic                                     req_last_cell,
   // Path length out
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0]   rsp_path_length,
   output logic                                     rsp_size_error,
   // Register writes
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [ldgp_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [ldgp_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   logic [ldgp_pkg::CSR_DATA_W-1:0] grid_rows_ff;
   logic [ldgp_pkg::CSR_DATA_W-1:0] grid_cols_ff;
   logic                            csr_write;

   ldgp_pkg::cmd_type    ctrl_cmd;
   ldgp_pkg::status_type dp_status;

   // Handshake views used by the checks below.
   logic                            last_take;
   logic                            rsp_good;
   logic                            rsp_bad;
   logic                            len_zero;

   // Register file: always ready; writes outside the list are dropped.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= ldgp_pkg::GRID_ROWS_RESET;
         grid_cols_ff <= ldgp_pkg::GRID_COLS_RESET;
      end else if (csr_write) begin
         if (csr_index == ldgp_pkg::REG_GRID_ROWS) begin
            grid_rows_ff <= csr_wdata;
         end
         if (csr_index == ldgp_pkg::REG_GRID_COLS) begin
            grid_cols_ff <= csr_wdata;
         end
      end
   end

   // Sequence loading, root scan, neighbor steps, pops and the result.
   ldgp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_cell (req_last_cell),
      .req_ready     (req_ready),
      .status        (dp_status),
      .cmd           (ctrl_cmd)
   );

   // Hold the grid, memo lengths, search stack and the result register.
   ldgp_dpath #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .grid_rows   (grid_rows_ff),
      .grid_cols   (grid_cols_ff),
      .cell_value  (req_cell_value),
      .cmd         (ctrl_cmd),
      .status      (dp_status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .path_length (rsp_path_length),
      .size_error  (rsp_size_error)
   );

   assign last_take = req_valid && req_ready && req_last_cell;
   assign rsp_good  = rsp_valid && !rsp_size_error;
   assign rsp_bad   = rsp_valid && rsp_size_error;
   assign len_zero  = rsp_path_length == '0;

   // A last item only enters with the result slot free.
   `LDGP_ASSERT_IMP(a_last_needs_slot, clock, reset, last_take, !rsp_valid, "slot busy")
   // An error result carries a zero length.
   `LDGP_ASSERT_IMP(a_error_zero_len, clock, reset, rsp_bad, len_zero, "error with length")
   // A completed search always finds at least one cell.
   `LDGP_ASSERT_IMP(a_good_len_nonzero, clock, reset, rsp_good, !len_zero, "zero length")
   // Finishing the search presents a result in the next cycle.
   `LDGP_ASSERT_NXT(a_finish_shows_rsp, clock, reset, ctrl_cmd.finish, rsp_good, "no result")

endmodule

// File: hdl/ldgp_dpath.sv
// Datapath: grid, memo and stack memories, top frame, counters and result register.
`timescale 1ns / 1ps

module ldgp_dpath #(
   parameter int MAX_ROWS   = ldgp_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = ldgp_pkg::MAX_COLS_DEF,
   parameter int VALUE_BITS = ldgp_pkg::VALUE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [ldgp_pkg::CSR_DATA_W-1:0]           grid_rows,
   input  logic [ldgp_pkg::CSR_DATA_W-1:0]           grid_cols,
   input  logic signed [VALUE_BITS-1:0]              cell_value,
   input  ldgp_pkg::cmd_type                         cmd,
   output ldgp_pkg::status_type                      status,
   input  logic                                      rsp_ready,
   output logic                                      rsp_valid,
   output logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0]    path_length,
   output logic                                      size_error
);

   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int RDIM_W = $clog2(MAX_ROWS + 1);
   localparam int CDIM_W = $clog2(MAX_COLS + 1);
   localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   typedef struct packed {
      logic [RIDX_W-1:0]     row;
      logic [CIDX_W-1:0]     col;
      logic [ADDR_W-1:0]     addr;
      ldgp_pkg::dir_type     dir;
      logic [CNT_W-1:0]      len;
      logic [VALUE_BITS-1:0] val;
   } frame_type;

   logic [VALUE_BITS-1:0] grid_mem [CELLS];
   logic [CNT_W-1:0]      memo_mem [CELLS];
   frame_type             stack_mem [CELLS];

   logic [VALUE_BITS-1:0] grid_rdata_ff;
   logic [CNT_W-1:0]      memo_rdata_ff;
   frame_type             stack_rdata_ff;

   logic [CNT_W-1:0]  cnt_ff;
   logic [RDIM_W-1:0] rows_ff;
   logic [CDIM_W-1:0] cols_ff;
   logic [CNT_W-1:0]  total_ff;
   logic [CELLS-1:0]  valid_ff;
   logic [CNT_W-1:0]  best_ff;
   logic [CNT_W-1:0]  start_ff;
   logic [RIDX_W-1:0] start_r_ff;
   logic [CIDX_W-1:0] start_c_ff;
   logic [CNT_W-1:0]  depth_ff;
   frame_type         top_ff;
   logic [RIDX_W-1:0] nb_r_ff;
   logic [CIDX_W-1:0] nb_c_ff;
   logic [ADDR_W-1:0] nb_addr_ff;
   logic [CNT_W-1:0]  child_len_ff;
   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  rsp_len_ff;
   logic              rsp_err_ff;

   logic [CNT_W-1:0]  cnt_inc;
   logic [RDIM_W-1:0] eff_rows;
   logic [CDIM_W-1:0] eff_cols;
   logic [CNT_W-1:0]  eff_total;
   logic              short_grid;
   logic              nb_ok;
   logic [RIDX_W-1:0] nb_r;
   logic [CIDX_W-1:0] nb_c;
   logic [ADDR_W-1:0] nb_addr;
   logic              nb_less;
   logic              nb_valid;
   logic              push;
   logic [CNT_W-1:0]  memo_plus;
   logic [CNT_W-1:0]  child_plus;
   logic              start_wrap;
   logic [ADDR_W-1:0] grid_raddr;
   logic [ADDR_W-1:0] stk_waddr;
   logic [ADDR_W-1:0] stk_raddr;
   frame_type         root_frame;
   frame_type         nb_frame;
   frame_type         parent_frame;

   // Clamp the size registers into 1..MAX.
   always_comb begin
      if (grid_rows == '0) begin
         eff_rows = RDIM_W'(1);
      end else if (int'(grid_rows) > MAX_ROWS) begin
         eff_rows = RDIM_W'(MAX_ROWS);
      end else begin
         eff_rows = RDIM_W'(grid_rows);
      end
      if (grid_cols == '0) begin
         eff_cols = CDIM_W'(1);
      end else if (int'(grid_cols) > MAX_COLS) begin
         eff_cols = CDIM_W'(MAX_COLS);
      end else begin
         eff_cols = CDIM_W'(grid_cols);
      end
   end

   assign eff_total  = CNT_W'(CNT_W'(eff_rows) * CNT_W'(eff_cols));
   assign cnt_inc    = (cnt_ff < CNT_W'(CELLS)) ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign short_grid = cnt_inc < eff_total;

   // Neighbor of the top frame in its current direction.
   always_comb begin
      nb_ok = 1'b0;
      nb_r  = top_ff.row;
      nb_c  = top_ff.col;
      case (top_ff.dir)
         ldgp_pkg::DIR_RIGHT: begin
            nb_ok = (CDIM_W'(top_ff.col) + CDIM_W'(1)) < cols_ff;
            nb_c  = top_ff.col + CIDX_W'(1);
         end
         ldgp_pkg::DIR_DOWN: begin
            nb_ok = (RDIM_W'(top_ff.row) + RDIM_W'(1)) < rows_ff;
            nb_r  = top_ff.row + RIDX_W'(1);
         end
         ldgp_pkg::DIR_LEFT: begin
            nb_ok = top_ff.col != '0;
            nb_c  = top_ff.col - CIDX_W'(1);
         end
         ldgp_pkg::DIR_UP: begin
            nb_ok = top_ff.row != '0;
            nb_r  = top_ff.row - RIDX_W'(1);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   assign nb_addr = ADDR_W'(CNT_W'(nb_r) * CNT_W'(cols_ff) + CNT_W'(nb_c));

   assign nb_less    = $signed(grid_rdata_ff) < $signed(top_ff.val);
   assign nb_valid   = valid_ff[nb_addr_ff];
   assign push       = cmd.check && nb_less && !nb_valid;
   assign memo_plus  = memo_rdata_ff + CNT_W'(1);
   assign child_plus = child_len_ff + CNT_W'(1);
   assign start_wrap = (CDIM_W'(start_c_ff) + CDIM_W'(1)) == cols_ff;

   assign grid_raddr = cmd.root_read ? start_ff[ADDR_W-1:0] : nb_addr;
   assign stk_waddr  = ADDR_W'(depth_ff - CNT_W'(1));
   assign stk_raddr  = ADDR_W'(depth_ff - CNT_W'(2));

   always_comb begin
      root_frame      = top_ff;
      root_frame.row  = start_r_ff;
      root_frame.col  = start_c_ff;
      root_frame.addr = start_ff[ADDR_W-1:0];
      root_frame.dir  = ldgp_pkg::DIR_RIGHT;
      root_frame.len  = CNT_W'(1);
      root_frame.val  = grid_rdata_ff;
      nb_frame        = top_ff;
      nb_frame.row    = nb_r_ff;
      nb_frame.col    = nb_c_ff;
      nb_frame.addr   = nb_addr_ff;
      nb_frame.dir    = ldgp_pkg::DIR_RIGHT;
      nb_frame.len    = CNT_W'(1);
      nb_frame.val    = grid_rdata_ff;
      // Parent comes back with the finished child's length folded in.
      parent_frame    = stack_rdata_ff;
      if (child_plus > stack_rdata_ff.len) begin
         parent_frame.len = child_plus;
      end
   end

   // Memories: one write and one registered read each per cycle.
   always_ff @(posedge clock) begin
      if (cmd.load_cell && (cnt_ff < CNT_W'(CELLS))) begin
         grid_mem[cnt_ff[ADDR_W-1:0]] <= cell_value;
      end
      grid_rdata_ff <= grid_mem[grid_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.retire) begin
         memo_mem[top_ff.addr] <= top_ff.len;
      end
      memo_rdata_ff <= memo_mem[nb_addr];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[stk_waddr] <= top_ff;
      end
      stack_rdata_ff <= stack_mem[stk_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         depth_ff     <= '0;
         valid_ff     <= '0;
         best_ff      <= '0;
         start_ff     <= '0;
         start_r_ff   <= '0;
         start_c_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.end_job) begin
            cnt_ff <= '0;
         end else if (cmd.load_cell) begin
            cnt_ff <= cnt_inc;
         end
         if ((cmd.end_job && short_grid) || cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.start) begin
            valid_ff   <= '0;
            best_ff    <= '0;
            start_ff   <= '0;
            start_r_ff <= '0;
            start_c_ff <= '0;
            depth_ff   <= '0;
         end
         if (cmd.root_skip || cmd.root_close) begin
            start_ff <= start_ff + CNT_W'(1);
            if (start_wrap) begin
               start_c_ff <= '0;
               start_r_ff <= start_r_ff + RIDX_W'(1);
            end else begin
               start_c_ff <= start_c_ff + CIDX_W'(1);
            end
         end
         if (cmd.root_close && (top_ff.len > best_ff)) begin
            best_ff <= top_ff.len;
         end
         if (cmd.root_push) begin
            depth_ff <= CNT_W'(1);
         end
         if (cmd.retire) begin
            valid_ff[top_ff.addr] <= 1'b1;
            depth_ff              <= depth_ff - CNT_W'(1);
         end
         if (push) begin
            depth_ff <= depth_ff + CNT_W'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.end_job) begin
         rows_ff  <= eff_rows;
         cols_ff  <= eff_cols;
         total_ff <= eff_total;
         if (short_grid) begin
            rsp_len_ff <= '0;
            rsp_err_ff <= 1'b1;
         end
      end
      if (cmd.finish) begin
         rsp_len_ff <= best_ff;
         rsp_err_ff <= 1'b0;
      end
      if (cmd.root_push) begin
         top_ff <= root_frame;
      end
      if (cmd.dir_next) begin
         top_ff.dir <= ldgp_pkg::dir_type'(top_ff.dir + ldgp_pkg::DIR_W'(1));
         nb_r_ff    <= nb_r;
         nb_c_ff    <= nb_c;
         nb_addr_ff <= nb_addr;
      end
      if (cmd.retire) begin
         child_len_ff <= top_ff.len;
      end
      if (cmd.check && nb_less) begin
         if (nb_valid) begin
            if (memo_plus > top_ff.len) begin
               top_ff.len <= memo_plus;
            end
         end else begin
            top_ff <= nb_frame;
         end
      end
      if (cmd.parent_load) begin
         top_ff <= parent_frame;
      end
   end

   assign status.short_grid = short_grid;
   assign status.root_done  = start_ff == total_ff;
   assign status.root_valid = valid_ff[start_ff[ADDR_W-1:0]];
   assign status.dir_done   = top_ff.dir == ldgp_pkg::DIR_DONE;
   assign status.nb_ok      = nb_ok;
   assign status.depth_gt1  = depth_ff > CNT_W'(1);
   assign status.rsp_busy   = rsp_valid_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign path_length = rsp_len_ff;
   assign size_error  = rsp_err_ff;

endmodule

// File: hdl/ldgp_ctrl.sv
// Controller: state machine that sequences loading and the depth-first search.
`timescale 1ns / 1ps

module ldgp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_cell,
   output logic                 req_ready,
   input  ldgp_pkg::status_type status,
   output ldgp_pkg::cmd_type    cmd
);

   ldgp_pkg::state_type state_ff;
   ldgp_pkg::state_type state_in;
   logic                accept;

   // A last item needs the result slot; other items load freely.
   assign req_ready = (state_ff == ldgp_pkg::ST_LOAD) && (!req_last_cell || !status.rsp_busy);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldgp_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ldgp_pkg::ST_LOAD: begin
            if (accept && req_last_cell && !status.short_grid) begin
               state_in = ldgp_pkg::ST_START;
            end
         end
         ldgp_pkg::ST_START: begin
            state_in = ldgp_pkg::ST_ROOT;
         end
         ldgp_pkg::ST_ROOT: begin
            if (status.root_done) begin
               state_in = ldgp_pkg::ST_FINISH;
            end else if (!status.root_valid) begin
               state_in = ldgp_pkg::ST_ROOT_LD;
            end
         end
         ldgp_pkg::ST_ROOT_LD: begin
            state_in = ldgp_pkg::ST_STEP;
         end
         ldgp_pkg::ST_STEP: begin
            if (!status.dir_done) begin
               if (status.nb_ok) begin
                  state_in = ldgp_pkg::ST_CHECK;
               end
            end else if (status.depth_gt1) begin
               state_in = ldgp_pkg::ST_POP;
            end else begin
               state_in = ldgp_pkg::ST_ROOT;
            end
         end
         ldgp_pkg::ST_CHECK: begin
            state_in = ldgp_pkg::ST_STEP;
         end
         ldgp_pkg::ST_POP: begin
            state_in = ldgp_pkg::ST_STEP;
         end
         ldgp_pkg::ST_FINISH: begin
            state_in = ldgp_pkg::ST_LOAD;
         end
         default: begin
            state_in = ldgp_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ldgp_pkg::ST_LOAD: begin
            cmd.load_cell = accept;
            cmd.end_job   = accept && req_last_cell;
         end
         ldgp_pkg::ST_START: begin
            cmd.start = 1'b1;
         end
         ldgp_pkg::ST_ROOT: begin
            if (!status.root_done) begin
               cmd.root_skip = status.root_valid;
               cmd.root_read = !status.root_valid;
            end
         end
         ldgp_pkg::ST_ROOT_LD: begin
            cmd.root_push = 1'b1;
         end
         ldgp_pkg::ST_STEP: begin
            if (!status.dir_done) begin
               cmd.dir_next = 1'b1;
            end else begin
               cmd.retire     = 1'b1;
               cmd.root_close = !status.depth_gt1;
            end
         end
         ldgp_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ldgp_pkg::ST_POP: begin
            cmd.parent_load = 1'b1;
         end
         ldgp_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: test/longest_decreasing_grid_path_test.sv
// Self-checking testbench for the longest decreasing grid path block.
`timescale 1ns / 1ps

module longest_decreasing_grid_path_test;

   localparam int VALUE_W    = ldgp_pkg::VALUE_BITS_DEF;
   localparam int CELL_LIMIT = ldgp_pkg::MAX_ROWS_DEF * ldgp_pkg::MAX_COLS_DEF;
   localparam int LENGTH_W   = $clog2(CELL_LIMIT + 1);
   localparam int RANDOM_ITEMS = 300;
   // Idle cycles granted before a register write and before the final verdict.
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 64;

   // Indexes with no register behind them; writes there must change nothing.
   localparam logic [ldgp_pkg::CSR_INDEX_W-1:0] REG_SPARE_A = ldgp_pkg::CSR_INDEX_W'(2);
   localparam logic [ldgp_pkg::CSR_INDEX_W-1:0] REG_SPARE_B = ldgp_pkg::CSR_INDEX_W'(3);

   typedef enum logic {
      ROW_CELL,
      ROW_CSR
   } plan_kind_type;

   typedef enum logic [1:0] {
      FILL_NARROW,
      FILL_WIDE,
      FILL_EXTREME,
      FILL_RAMP
   } fill_mode_type;

   typedef enum logic [1:0] {
      JOB_EXACT,
      JOB_EXTRA,
      JOB_EARLY
   } job_kind_type;

   // One line of the directed plan: a register write or a cell item.
   typedef struct packed {
      plan_kind_type                   kind;
      logic [ldgp_pkg::CSR_INDEX_W-1:0] index;
      logic [ldgp_pkg::CSR_DATA_W-1:0]  wdata;
      logic signed [VALUE_W-1:0]       value;
      logic                            last;
      logic                            typed;
      logic [LENGTH_W-1:0]             length;
      logic                            error;
   } plan_row_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] length;
      logic                error;
   } path_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic signed [VALUE_W-1:0]        req_cell_value = '0;
   logic                             req_last_cell = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [LENGTH_W-1:0]              rsp_path_length;
   logic                             rsp_size_error;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ldgp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ldgp_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow of the block: register copies, cells of the open job, and the
   // results still owed on the rsp channel, oldest first.
   logic [ldgp_pkg::CSR_DATA_W-1:0]  rows_reg = ldgp_pkg::GRID_ROWS_RESET;
   logic [ldgp_pkg::CSR_DATA_W-1:0]  cols_reg = ldgp_pkg::GRID_COLS_RESET;
   logic signed [VALUE_W-1:0]        grid_cells [CELL_LIMIT];
   int                               cells_taken = 0;
   path_result_type                  path_results_due [$];
   path_result_type                  head_due;
   plan_row_type                     plan [$];
   int                               mismatches = 0;
   // High during the stretch where neither side idles.
   bit                               calm = 1'b0;

   longest_decreasing_grid_path u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_value  (req_cell_value),
      .req_last_cell   (req_last_cell),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_path_length (rsp_path_length),
      .rsp_size_error  (rsp_size_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("longest_decreasing_grid_path regression: fail");
      $finish;
   end

   // Receiver: back-pressure on about a third of the cycles, none while calm.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
   end

   // Compare every accepted result with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (path_results_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, got length %0d error %0b",
                     $time, rsp_path_length, rsp_size_error);
            mismatches++;
         end else begin
            head_due = path_results_due.pop_front();
            if (rsp_path_length !== head_due.length) begin
               $display("%0t: path_length mismatch: expected %0d, got %0d",
                        $time, head_due.length, rsp_path_length);
               mismatches++;
            end
            if (rsp_size_error !== head_due.error) begin
               $display("%0t: size_error mismatch: expected %0b, got %0b",
                        $time, head_due.error, rsp_size_error);
               mismatches++;
            end
         end
      end
   end

   // Clamp a dimension register the way the block reads it: 0 means 1.
   function automatic int eff_dim(input logic [ldgp_pkg::CSR_DATA_W-1:0] raw,
                                  input int maxv);
      if (raw == 0) return 1;
      if (int'(raw) > maxv) return maxv;
      return int'(raw);
   endfunction

   // Longest strictly decreasing 4-neighbor path over the loaded cells.
   // Relax path lengths until nothing grows; each pass extends chains by at least one.
   function automatic logic [LENGTH_W-1:0] longest_descent(input int rows, input int cols);
      int span [CELL_LIMIT];
      int total, best, r, c, nr, nc, nb;
      bit moved;
      total = rows * cols;
      for (int i = 0; i < total; i++) span[i] = 1;
      do begin
         moved = 1'b0;
         for (int i = 0; i < total; i++) begin
            r = i / cols;
            c = i % cols;
            for (int d = ldgp_pkg::DIR_RIGHT; d <= ldgp_pkg::DIR_UP; d++) begin
               case (ldgp_pkg::dir_type'(d))
                  ldgp_pkg::DIR_RIGHT: begin nr = r;     nc = c + 1; end
                  ldgp_pkg::DIR_DOWN:  begin nr = r + 1; nc = c;     end
                  ldgp_pkg::DIR_LEFT:  begin nr = r;     nc = c - 1; end
                  default:             begin nr = r - 1; nc = c;     end
               endcase
               if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
                  nb = nr * cols + nc;
                  if (grid_cells[nb] < grid_cells[i] && span[nb] + 1 > span[i]) begin
                     span[i] = span[nb] + 1;
                     moved = 1'b1;
                  end
               end
            end
         end
      end while (moved);
      best = 0;
      for (int i = 0; i < total; i++) if (span[i] > best) best = span[i];
      return LENGTH_W'(best);
   endfunction

   function automatic logic signed [VALUE_W-1:0] draw_value(input fill_mode_type mode,
                                                            input int idx);
      int v;
      case (mode)
         FILL_NARROW: v = int'($urandom_range(0, 7)) - 4;
         FILL_WIDE:   v = int'($urandom);
         FILL_RAMP:   v = idx * 3 + int'($urandom_range(0, 4));
         default: begin
            case ($urandom_range(0, 4))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = 0;
               3:       v = -1;
               default: v = int'($urandom);
            endcase
         end
      endcase
      return VALUE_W'(v);
   endfunction

   function automatic plan_row_type cell_row(input logic signed [VALUE_W-1:0] value,
                                             input logic last, input logic typed,
                                             input logic [LENGTH_W-1:0] length,
                                             input logic error);
      plan_row_type row;
      row = '0;
      row.kind   = ROW_CELL;
      row.value  = value;
      row.last   = last;
      row.typed  = typed;
      row.length = length;
      row.error  = error;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [ldgp_pkg::CSR_INDEX_W-1:0] index,
                                            input logic [ldgp_pkg::CSR_DATA_W-1:0] wdata);
      plan_row_type row;
      row = '0;
      row.kind  = ROW_CSR;
      row.index = index;
      row.wdata = wdata;
      return row;
   endfunction

   // Called right after a falling edge. Record the cell in the shadow grid,
   // queue the result a last cell owes, then hold the item until accepted.
   task automatic send_cell(input logic signed [VALUE_W-1:0] value, input logic last,
                            input logic typed, input logic [LENGTH_W-1:0] length,
                            input logic error);
      int rows, cols;
      path_result_type due;
      if (cells_taken < CELL_LIMIT) begin
         grid_cells[cells_taken] = value;
         cells_taken++;
      end
      if (last) begin
         // Registers as they stand at the last cell decide the grid shape.
         rows = eff_dim(rows_reg, ldgp_pkg::MAX_ROWS_DEF);
         cols = eff_dim(cols_reg, ldgp_pkg::MAX_COLS_DEF);
         if (typed) begin
            due.length = length;
            due.error  = error;
         end else if (cells_taken < rows * cols) begin
            due.length = '0;
            due.error  = 1'b1;
         end else begin
            due.length = longest_descent(rows, cols);
            due.error  = 1'b0;
         end
         path_results_due.push_back(due);
         cells_taken = 0;
      end
      // Idle on about a third of the cycles ahead of each item.
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_value <= value;
      req_last_cell  <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [ldgp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ldgp_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == ldgp_pkg::REG_GRID_ROWS) rows_reg = data;
      else if (index == ldgp_pkg::REG_GRID_COLS) cols_reg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drop req_valid, wait for every owed result, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (path_results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int random_items, phase_no, rows_w, cols_w, total, jobs, count, pick, p;
      job_kind_type  kind;
      fill_mode_type mode;

      random_items = 0;
      phase_no     = 0;

      // Directed plan. Early last flags and single-cell grids have obvious
      // answers and are typed in; the other rows go through the predictor.
      // Early last flag at the reset shape of 16 x 16.
      plan.push_back(cell_row(16'sh7fff, 1'b1, 1'b1, 0, 1'b1));
      // 1 x 1 grid: every lone cell is a path of one, whatever its value.
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_ROWS, 5'd1));
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_COLS, 5'd1));
      plan.push_back(cell_row(-16'sd32768, 1'b1, 1'b1, 1, 1'b0));
      plan.push_back(cell_row(16'sd32767, 1'b1, 1'b1, 1, 1'b0));
      plan.push_back(cell_row(16'sd0, 1'b1, 1'b1, 1, 1'b0));
      // Two cells on a 1 x 1 grid: the extra last-flag cell is ignored by the search.
      plan.push_back(cell_row(-16'sd1, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd5, 1'b1, 1'b1, 1, 1'b0));
      // Zero rows acts as one, columns above the maximum act as the maximum.
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_ROWS, 5'd0));
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_COLS, 5'd31));
      plan.push_back(cell_row(16'sd3, 1'b1, 1'b1, 0, 1'b1));
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_ROWS, 5'd31));
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_COLS, 5'd0));
      plan.push_back(cell_row(-16'sd3, 1'b1, 1'b1, 0, 1'b1));
      // 2 x 2 grids: a full cycle, one with a trailing extra cell, one short.
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_ROWS, 5'd2));
      plan.push_back(csr_row(ldgp_pkg::REG_GRID_COLS, 5'd2));
      plan.push_back(cell_row(16'sd4, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd3, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd1, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd2, 1'b1, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd9, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(-16'sd9, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd0, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd7, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd100, 1'b1, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd8, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(16'sd6, 1'b0, 1'b0, 0, 1'b0));
      plan.push_back(cell_row(-16'sd2, 1'b1, 1'b1, 0, 1'b1));

      // Hold reset, then release it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(plan[i].index, plan[i].wdata);
         end else begin
            send_cell(plan[i].value, plan[i].last, plan[i].typed, plan[i].length,
                      plan[i].error);
         end
      end

      // Full 16 x 16 snake of falling values: the path covers every cell.
      // Run it with no idling on either side.
      wait_idle();
      csr_write(ldgp_pkg::REG_GRID_ROWS, 5'd16);
      csr_write(ldgp_pkg::REG_GRID_COLS, 5'd16);
      calm = 1'b1;
      for (int i = 0; i < CELL_LIMIT; i++) begin
         p = (((i / 16) % 2) == 0) ? i : (i / 16) * 16 + 15 - (i % 16);
         send_cell(VALUE_W'(1000 - p), i == CELL_LIMIT - 1, 1'b0, 0, 1'b0);
      end
      calm = 1'b0;

      // Random phases: new shape, then one job on it, or 2 to 6 back-to-back jobs on grids of 64 cells or fewer.
      while (random_items < RANDOM_ITEMS) begin
         calm = (phase_no == 3 || phase_no == 4);
         pick = $urandom_range(0, 15);
         case (pick)
            0: begin rows_w = 16; cols_w = 16; end
            1: begin rows_w = $urandom_range(17, 31); cols_w = $urandom_range(0, 2); end
            2: begin rows_w = $urandom_range(0, 2); cols_w = $urandom_range(17, 31); end
            3: begin rows_w = 0; cols_w = 0; end
            4: begin rows_w = $urandom_range(6, 16); cols_w = $urandom_range(1, 4); end
            default: begin rows_w = $urandom_range(1, 5); cols_w = $urandom_range(1, 5); end
         endcase
         wait_idle();
         if (phase_no == 1) begin
            csr_write(REG_SPARE_A, ldgp_pkg::CSR_DATA_W'($urandom));
            csr_write(REG_SPARE_B, ldgp_pkg::CSR_DATA_W'($urandom));
         end
         csr_write(ldgp_pkg::REG_GRID_ROWS, ldgp_pkg::CSR_DATA_W'(rows_w));
         csr_write(ldgp_pkg::REG_GRID_COLS, ldgp_pkg::CSR_DATA_W'(cols_w));
         total = eff_dim(ldgp_pkg::CSR_DATA_W'(rows_w), ldgp_pkg::MAX_ROWS_DEF)
               * eff_dim(ldgp_pkg::CSR_DATA_W'(cols_w), ldgp_pkg::MAX_COLS_DEF);
         jobs = (total > 64) ? 1 : $urandom_range(2, 6);
         repeat (jobs) begin
            pick = $urandom_range(0, 99);
            if (pick < 70 || total == 1) kind = (pick >= 85) ? JOB_EXTRA : JOB_EXACT;
            else kind = (pick < 85) ? JOB_EXTRA : JOB_EARLY;
            case (kind)
               JOB_EXTRA: count = total + $urandom_range(1, 3);
               JOB_EARLY: count = $urandom_range(1, total - 1);
               default:   count = total;
            endcase
            mode = fill_mode_type'($urandom_range(0, 3));
            for (int k = 0; k < count; k++) begin
               send_cell(draw_value(mode, k), k == count - 1, 1'b0, 0, 1'b0);
            end
            random_items += count;
         end
         phase_no++;
      end

      calm = 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("longest_decreasing_grid_path regression: pass");
      end else begin
         $display("longest_decreasing_grid_path regression: fail");
      end
      $finish;
   end

endmodule
